>>> sv/klk_pkg.sv
// Package for the keypad combination lock: sizes, key event codes and the
// state and result records that pass between the step logic and the top level.
// No dependencies.
package klk_pkg;

   localparam int CODE_DIGITS = 4;
   localparam int DIGIT_W     = 4;
   localparam int POS_W       = 2;
   localparam int CODE_W      = CODE_DIGITS * DIGIT_W;
   localparam int MODE_W      = 4;

   localparam logic [DIGIT_W-1:0] DIGIT_BLANK = 4'd10;
   localparam logic [DIGIT_W-1:0] DIGIT_MAX   = 4'd9;
   localparam logic [POS_W-1:0]   POS_LAST    = POS_W'(CODE_DIGITS - 1);

   localparam logic [MODE_W-1:0] MODE_START        = 4'd0;
   localparam logic [MODE_W-1:0] MODE_RIGHT        = 4'd1;
   localparam logic [MODE_W-1:0] MODE_LEFT         = 4'd2;
   localparam logic [MODE_W-1:0] MODE_UP           = 4'd3;
   localparam logic [MODE_W-1:0] MODE_DOWN         = 4'd4;
   localparam logic [MODE_W-1:0] MODE_INNER_OK     = 4'd5;
   localparam logic [MODE_W-1:0] MODE_OUTER_DIGIT  = 4'd6;
   localparam logic [MODE_W-1:0] MODE_BACKSPACE    = 4'd7;
   localparam logic [MODE_W-1:0] MODE_OUTER_OK     = 4'd8;

   typedef logic [CODE_DIGITS-1:0][DIGIT_W-1:0] entry_type;

   typedef struct packed {
      entry_type          inner_digits;
      entry_type          outer_digits;
      entry_type          stored_digits;
      logic [POS_W-1:0]   inner_pos;
      logic [DIGIT_W-1:0] digit_value;
      logic [POS_W-1:0]   outer_pos;
      logic               edit_mode;
      logic               active;
   } lock_state_type;

   typedef struct packed {
      logic               unlocked;
      logic               modifying;
      logic [POS_W-1:0]   inner_cursor;
      logic [DIGIT_W-1:0] inner_value;
      logic [POS_W-1:0]   outer_cursor;
      logic               code_saved;
      logic [CODE_W-1:0]  saved_code;
      logic               session_active;
   } lock_result_type;

endpackage

>>> sv/klk_req_if.sv
// Key event channel: valid/ready handshake with the event payload.
// Depends on klk_pkg.
interface klk_req_if;
   import klk_pkg::*;

   logic              valid;
   logic              ready;
   logic [MODE_W-1:0] mode;
   logic [DIGIT_W-1:0] digit;
   logic              long_press;

   modport source (output valid, mode, digit, long_press, input ready);
   modport sink   (input valid, mode, digit, long_press, output ready);
endinterface

>>> sv/klk_rsp_if.sv
// Result channel: valid/ready handshake with the lock status payload.
// Depends on klk_pkg.
interface klk_rsp_if;
   import klk_pkg::*;

   logic               valid;
   logic               ready;
   logic               unlocked;
   logic               modifying;
   logic [POS_W-1:0]   inner_cursor;
   logic [DIGIT_W-1:0] inner_value;
   logic [POS_W-1:0]   outer_cursor;
   logic               code_saved;
   logic [CODE_W-1:0]  saved_code;
   logic               session_active;

   modport source (output valid, unlocked, modifying, inner_cursor, inner_value,
                   outer_cursor, code_saved, saved_code, session_active,
                   input ready);
   modport sink   (input valid, unlocked, modifying, inner_cursor, inner_value,
                   outer_cursor, code_saved, saved_code, session_active,
                   output ready);
endinterface

>>> sv/klk_step.sv
// Next-state and result logic for one key event of the combination lock.
// Depends on klk_pkg.
module klk_step (
   input  klk_pkg::lock_state_type       cur,
   input  logic [klk_pkg::MODE_W-1:0]    mode,
   input  logic [klk_pkg::DIGIT_W-1:0]   digit,
   input  logic                          long_press,
   input  logic [klk_pkg::CODE_W-1:0]    initial_code,
   output klk_pkg::lock_state_type       nxt,
   output klk_pkg::lock_result_type      res
);
   import klk_pkg::*;

   function automatic logic entry_match(entry_type e, entry_type s);
      logic ok;
      ok = 1'b1;
      for (int i = 0; i < CODE_DIGITS; i++) begin
         if (e[i] > DIGIT_MAX || e[i] != s[i]) begin
            ok = 1'b0;
         end
      end
      return ok;
   endfunction

   lock_state_type st;
   logic           unlock;
   logic           saved;
   logic           in_ok;
   logic           is_confirm;

   always_comb begin
      st     = cur;
      unlock = 1'b0;
      saved  = 1'b0;
      in_ok  = 1'b0;
      is_confirm = (mode == MODE_INNER_OK) || (mode == MODE_OUTER_OK);

      if (mode == MODE_START) begin
         for (int i = 0; i < CODE_DIGITS; i++) begin
            st.stored_digits[i] = initial_code[(CODE_DIGITS-1-i)*DIGIT_W +: DIGIT_W];
         end
         st.inner_pos       = '0;
         st.outer_pos       = '0;
         st.digit_value     = '0;
         st.edit_mode       = 1'b0;
         st.active          = 1'b1;
         st.inner_digits[0] = '0;
      end else if (cur.active) begin
         unique case (mode)
            MODE_RIGHT: begin
               st.inner_pos   = (cur.inner_pos == POS_LAST) ? '0 : cur.inner_pos + 1'b1;
               st.digit_value = '0;
            end
            MODE_LEFT: begin
               st.inner_pos = (cur.inner_pos == '0) ? POS_LAST : cur.inner_pos - 1'b1;
            end
            MODE_UP: begin
               st.digit_value = (cur.digit_value >= DIGIT_MAX) ? '0
                              : cur.digit_value + 1'b1;
            end
            MODE_DOWN: begin
               st.digit_value = (cur.digit_value == '0 || cur.digit_value > DIGIT_MAX)
                              ? DIGIT_MAX : cur.digit_value - 1'b1;
            end
            MODE_OUTER_DIGIT: begin
               if (digit <= DIGIT_MAX) begin
                  st.outer_digits[cur.outer_pos] = digit;
                  if (cur.outer_pos != POS_LAST) begin
                     st.outer_pos = cur.outer_pos + 1'b1;
                  end
               end
            end
            MODE_BACKSPACE: begin
               if (cur.outer_pos != '0) begin
                  st.outer_pos = cur.outer_pos - 1'b1;
               end
            end
            default: begin
            end
         endcase

         if (cur.edit_mode) begin
            st.stored_digits[st.inner_pos] = st.digit_value;
            if (mode == MODE_INNER_OK) begin
               st.digit_value = '0;
               st.edit_mode   = 1'b0;
               saved          = 1'b1;
               unlock = entry_match(st.inner_digits, st.stored_digits)
                     || entry_match(st.outer_digits, st.stored_digits);
            end
         end else begin
            st.inner_digits[st.inner_pos] = st.digit_value;
            if (is_confirm) begin
               in_ok = entry_match(st.inner_digits, st.stored_digits);
               if (mode == MODE_INNER_OK && long_press && in_ok) begin
                  st.edit_mode = 1'b1;
                  st.stored_digits[st.inner_pos] = st.digit_value;
               end else begin
                  unlock = in_ok || entry_match(st.outer_digits, st.stored_digits);
               end
            end
         end

         if (unlock) begin
            st.digit_value                   = '0;
            st.inner_digits[CODE_DIGITS-1]   = DIGIT_BLANK;
            st.outer_digits[CODE_DIGITS-1]   = DIGIT_BLANK;
            st.edit_mode                     = 1'b0;
            st.active                        = 1'b0;
         end
      end

      nxt                = st;
      res.unlocked       = unlock;
      res.modifying      = st.edit_mode;
      res.inner_cursor   = st.inner_pos;
      res.inner_value    = st.digit_value;
      res.outer_cursor   = st.outer_pos;
      res.code_saved     = saved;
      for (int i = 0; i < CODE_DIGITS; i++) begin
         res.saved_code[(CODE_DIGITS-1-i)*DIGIT_W +: DIGIT_W] = st.stored_digits[i];
      end
      res.session_active = st.active;
   end

endmodule

>>> sv/keypad_combination_lock_top.sv
// Keypad combination lock top level: lock state registers, code register
// and the result register. Depends on klk_pkg, klk_req_if, klk_rsp_if, klk_step.
//
// Usage:
//   req_chan carries one key event per beat (mode, digit, long_press).
//   rsp_chan returns exactly one status beat per key event, in order.
//   csr_we/csr_wdata load the initial code, taken into the stored code by
//   a start event; write it only while no event is in flight.
// Timing:
//   An event is accepted when req_chan.valid and req_chan.ready are high.
//   Its result is registered and shows on rsp_chan in the next cycle.
//   Throughput is one event per cycle while rsp_chan.ready stays high; the
//   state update in klk_step is combinational.
//   req_chan.ready is high while the result register is empty or its beat
//   is taken in the same cycle, so a stalled receiver holds the result and
//   stalls the sender after one beat.
// Reset:
//   Synchronous, active high. Clears the session, cursors, stored code and
//   initial code; both entries return to zeros with a blank last digit.
module keypad_combination_lock_top (
   input  logic                         clock,
   input  logic                         reset,
   klk_req_if.sink                      req_chan,
   klk_rsp_if.source                    rsp_chan,
   input  logic                         csr_we,
   input  logic [klk_pkg::CODE_W-1:0]   csr_wdata
);
   import klk_pkg::*;

   lock_state_type  state_ff, state_in, step_state;
   lock_result_type res_ff, step_res;
   logic            rsp_valid_ff, rsp_valid_in;
   logic [CODE_W-1:0] code_ff, code_in;
   logic            accept;
   lock_state_type  state_reset;

   always_comb begin
      state_reset = '0;
      state_reset.inner_digits[CODE_DIGITS-1] = DIGIT_BLANK;
      state_reset.outer_digits[CODE_DIGITS-1] = DIGIT_BLANK;
   end

   assign req_chan.ready = !rsp_valid_ff || rsp_chan.ready;
   assign accept         = req_chan.valid && req_chan.ready;

   klk_step u_step (
      .cur          (state_ff),
      .mode         (req_chan.mode),
      .digit        (req_chan.digit),
      .long_press   (req_chan.long_press),
      .initial_code (code_ff),
      .nxt          (step_state),
      .res          (step_res)
   );

   assign state_in     = accept ? step_state : state_ff;
   assign rsp_valid_in = accept ? 1'b1 : (rsp_valid_ff && !rsp_chan.ready);
   assign code_in      = csr_we ? csr_wdata : code_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= state_reset;
         rsp_valid_ff <= 1'b0;
         code_ff      <= '0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
         code_ff      <= code_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         res_ff <= step_res;
      end
   end

   assign rsp_chan.valid          = rsp_valid_ff;
   assign rsp_chan.unlocked       = res_ff.unlocked;
   assign rsp_chan.modifying      = res_ff.modifying;
   assign rsp_chan.inner_cursor   = res_ff.inner_cursor;
   assign rsp_chan.inner_value    = res_ff.inner_value;
   assign rsp_chan.outer_cursor   = res_ff.outer_cursor;
   assign rsp_chan.code_saved     = res_ff.code_saved;
   assign rsp_chan.saved_code     = res_ff.saved_code;
   assign rsp_chan.session_active = res_ff.session_active;

endmodule
